@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hdl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Opcodes, sequence lengths and the result type of the I2C bit sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam int unsigned BITS_PER_BYTE = 8;
  localparam int unsigned STEP_W        = 5;

  localparam logic [STEP_W-1:0] BIT_STEPS  = STEP_W'(2 * BITS_PER_BYTE);
  localparam logic [STEP_W-1:0] LEN_SHORT  = STEP_W'(3);
  localparam logic [STEP_W-1:0] LEN_WRITE  = STEP_W'(2 * BITS_PER_BYTE + 2);
  localparam logic [STEP_W-1:0] LEN_READ   = STEP_W'(2 * BITS_PER_BYTE + 4);
  localparam logic [STEP_W-1:0] READ_ACK_HIGH = STEP_W'(2 * BITS_PER_BYTE + 2);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rd;
    logic       sack;
  } res_t;

endpackage

@@ hdl/i2cms_seq.sv @@
// ----------------------------------------------------------------------------
// i2cms_seq
// Sequencer state and the per-tick line logic of the I2C master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [2:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic              ack_after_read,
  input  logic              sda_in,
  output i2cms_pkg::res_t   res
);
  import i2cms_pkg::*;

  logic [2:0]        active_command, active_command_next;
  logic [STEP_W-1:0] step_count, step_count_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic              ack_choice, ack_choice_next;
  logic              scl_reg, scl_reg_next;
  logic              sda_reg, sda_reg_next;
  logic              drive_reg, drive_reg_next;
  logic              ack_seen, ack_seen_next;

  logic              launch;
  logic [2:0]        cmd;
  logic [STEP_W-1:0] t;
  logic [STEP_W-1:0] t_inc;
  logic [STEP_W-1:0] len;
  logic [7:0]        sh;
  logic              ackc;
  logic              scl_n, sda_n, drv_n, seen_n;
  logic              done;

  always_comb begin
    launch = (active_command == OP_IDLE) && (opcode >= OP_START) && (opcode <= OP_READ);
    cmd    = launch ? opcode : active_command;
    t      = launch ? '0 : step_count;
    sh     = launch ? ((opcode == OP_WRITE) ? data_byte : 8'h00) : shift_reg;
    ackc   = launch ? ack_after_read : ack_choice;
    seen_n = launch ? 1'b0 : ack_seen;
    t_inc  = t + STEP_W'(1);
    scl_n  = scl_reg;
    sda_n  = sda_reg;
    drv_n  = drive_reg;

    case (cmd)
      OP_START: begin
        if (t == STEP_W'(0)) begin
          scl_n = 1'b1;
          sda_n = 1'b1;
        end else if (t == STEP_W'(1)) begin
          sda_n = 1'b0;
        end else begin
          scl_n = 1'b0;
        end
        drv_n = 1'b1;
      end
      OP_STOP: begin
        if (t == STEP_W'(0)) begin
          scl_n = 1'b0;
          sda_n = 1'b0;
        end else if (t == STEP_W'(1)) begin
          scl_n = 1'b1;
        end else begin
          sda_n = 1'b1;
        end
        drv_n = 1'b1;
      end
      OP_WRITE: begin
        if (t < BIT_STEPS) begin
          drv_n = 1'b1;
          if (!t[0]) begin
            scl_n = 1'b0;
            sda_n = sh[7];
          end else begin
            scl_n = 1'b1;
            sh    = {sh[6:0], 1'b0};
          end
        end else if (t == BIT_STEPS) begin
          scl_n = 1'b0;
          drv_n = 1'b0;
        end else begin
          scl_n  = 1'b1;
          drv_n  = 1'b0;
          seen_n = !sda_in;
        end
      end
      OP_READ: begin
        if (t < BIT_STEPS) begin
          drv_n = 1'b0;
          if (!t[0]) begin
            scl_n = 1'b0;
          end else begin
            scl_n = 1'b1;
            sh    = {sh[6:0], sda_in};
          end
        end else begin
          drv_n = 1'b1;
          sda_n = !ackc;
          scl_n = (t == READ_ACK_HIGH);
        end
      end
      default: begin
      end
    endcase

    case (cmd)
      OP_WRITE: len = LEN_WRITE;
      OP_READ:  len = LEN_READ;
      default:  len = LEN_SHORT;
    endcase

    done = (cmd != OP_IDLE) && (t_inc >= len);

    res.scl   = scl_n;
    res.sda   = drv_n ? sda_n : 1'b1;
    res.drive = drv_n;
    res.busy  = (cmd != OP_IDLE);
    res.done  = done;
    res.rd    = (done && cmd == OP_READ) ? sh : 8'h00;
    res.sack  = done && (cmd == OP_WRITE) && seen_n;

    active_command_next = done ? OP_IDLE : cmd;
    step_count_next     = (done || cmd == OP_IDLE) ? '0 : t_inc;
    shift_reg_next      = sh;
    ack_choice_next     = ackc;
    ack_seen_next       = seen_n;
    scl_reg_next        = (done && cmd == OP_WRITE) ? 1'b0 : scl_n;
    drive_reg_next      = (done && cmd == OP_WRITE) ? 1'b1 : drv_n;
    sda_reg_next        = sda_n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_command <= OP_IDLE;
      step_count     <= '0;
      shift_reg      <= 8'h00;
      ack_choice     <= 1'b0;
      scl_reg        <= 1'b1;
      sda_reg        <= 1'b1;
      drive_reg      <= 1'b1;
      ack_seen       <= 1'b0;
    end else if (adv) begin
      active_command <= active_command_next;
      step_count     <= step_count_next;
      shift_reg      <= shift_reg_next;
      ack_choice     <= ack_choice_next;
      scl_reg        <= scl_reg_next;
      sda_reg        <= sda_reg_next;
      drive_reg      <= drive_reg_next;
      ack_seen       <= ack_seen_next;
    end
  end

endmodule

@@ hdl/i2c_master_bit_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// I2C master line sequencer that advances one delay tick per input beat.
//
//   channel | handshake          | payload
//   input   | in_valid/in_ready  | opcode, data_byte, ack_after_read, sda_in
//   output  | out_valid/out_ready| scl_level, sda_level, sda_drive, busy_res,
//           |                    | done_res, read_data, slave_ack
//
// One input beat is accepted every cycle while the output is not stalled, and yields one output beat.
// Each beat passes through the input register, then the result register.
// The sequencer state steps once per beat as it leaves the input register.
// Reset clears both stage valids and returns the lines to idle-high.
// A stalled output holds both stages and drops in_ready once they are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [7:0] data_byte,
  input  logic       ack_after_read,
  input  logic       sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       scl_level,
  output logic       sda_level,
  output logic       sda_drive,
  output logic       busy_res,
  output logic       done_res,
  output logic [7:0] read_data,
  output logic       slave_ack
);
  import i2cms_pkg::*;

  logic       stage_valid;
  logic [2:0] op_q;
  logic [7:0] data_q;
  logic       ack_q;
  logic       sda_q;
  logic       adv;
  res_t       res;
  res_t       res_q;

  assign adv      = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= opcode;
      data_q <= data_byte;
      ack_q  <= ack_after_read;
      sda_q  <= sda_in;
    end
  end

  i2cms_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .opcode         (op_q),
    .data_byte      (data_q),
    .ack_after_read (ack_q),
    .sda_in         (sda_q),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign scl_level = res_q.scl;
  assign sda_level = res_q.sda;
  assign sda_drive = res_q.drive;
  assign busy_res  = res_q.busy;
  assign done_res  = res_q.done;
  assign read_data = res_q.rd;
  assign slave_ack = res_q.sack;

endmodule

@@ hdl/i2cms_checker.sv @@
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks on the I2C bit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2cms_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] read_data,
  input logic       slave_ack
);

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(done_res) && $stable(read_data) && $stable(scl_level))
  `ASSERT_IMPLY(a_done_busy, clk, rst, out_valid && done_res, busy_res)
  `ASSERT_IMPLY(a_released_high, clk, rst, out_valid && !sda_drive, sda_level)
  `ASSERT_IMPLY(a_result_on_done, clk, rst, out_valid && (slave_ack || read_data != 8'h00), done_res)
  `ASSERT_IMPLY(a_release_busy, clk, rst, out_valid && !sda_drive, busy_res)

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (.*);
